### sv/dual_hbridge_pwm_driver_macros.svh
// Assertion macros for the dual H-bridge PWM driver checker.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef DUAL_HBRIDGE_PWM_DRIVER_MACROS_SVH
`define DUAL_HBRIDGE_PWM_DRIVER_MACROS_SVH

// Plain clocked property.
`define HBPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication: when ante holds, cons must hold (same or later cycle per op).
`define HBPD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/hbpd_pkg.sv
// Shared types and constants for the dual H-bridge PWM driver.
// No dependencies.
package hbpd_pkg;

	localparam int CNT_W         = 7;
	localparam int SPEED_W       = 8;
	localparam int SPEED_RES_DEF = 100;

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_UPDATE = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// Per-channel command for one processed word.
	typedef struct packed {
		logic                      tick;
		logic                      apply;
		logic signed [SPEED_W-1:0] speed;
	} chan_ctrl_t;

endpackage

### sv/dual_hbridge_pwm_driver.sv
// Dual H-bridge slow-decay PWM driver, top level.
// Depends on hbpd_pkg and hbpd_chan.
//
// Usage:
//   Input words (kind, speed_a, speed_b, fault_pin) arrive on in_valid/in_stall
//   and are taken at an edge with in_valid high and in_stall low. kind selects
//   a timer tick, a control update (fault sampling, sleep and speeds) or a
//   fault clear; the unused code leaves the state alone.
//   Each word yields one result word (pins, sleep_n, fault flags) on
//   out_valid/out_stall, taken at an edge with out_valid high, out_stall low.
//   The word lands in an input register and moves into the output register
//   once the output can advance; out_valid then rises. Throughput: one word
//   per cycle while out_stall is low, set by the single state update between
//   the two registers. When out_stall holds, the result is kept stable; one
//   more word is taken into the input register, then in_stall rises until
//   the output drains. auto_clear is written on cfg_valid/cfg_ready (always
//   ready); the user must write it only while idle, which the block does not
//   enforce. Reset: counters 0, compares at the resolution (all pins high),
//   driver asleep, fault latch clear, auto_clear 1, both channels empty.
module dual_hbridge_pwm_driver #(
	parameter int SPEED_RESOLUTION = hbpd_pkg::SPEED_RES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          kind,
	input  logic signed [hbpd_pkg::SPEED_W-1:0] speed_a,
	input  logic signed [hbpd_pkg::SPEED_W-1:0] speed_b,
	input  logic                                fault_pin,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                pin_a1,
	output logic                                pin_a2,
	output logic                                pin_b1,
	output logic                                pin_b2,
	output logic                                sleep_n,
	output logic                                fault_active,
	output logic                                fault_event
);

	localparam int SW = hbpd_pkg::SPEED_W;

	logic                 valid_s1;
	logic [1:0]           kind_s1;
	logic signed [SW-1:0] speed_a_s1, speed_b_s1;
	logic                 fault_pin_s1;

	logic auto_clear_q, latch_q, sleep_q;
	logic out_valid_q;
	logic pin_a1_q, pin_a2_q, pin_b1_q, pin_b2_q, event_q;

	logic adv, accept, proc;
	logic latch_nxt, sleep_nxt, event_nxt;
	hbpd_pkg::chan_ctrl_t ctrl_a, ctrl_b;
	logic pa1, pa2, pb1, pb2;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !adv;
	assign accept    = in_valid && !in_stall;
	assign proc      = valid_s1 && adv;

	always_comb begin
		latch_nxt    = latch_q;
		sleep_nxt    = sleep_q;
		event_nxt    = 1'b0;
		ctrl_a.tick  = 1'b0;
		ctrl_a.apply = 1'b0;
		ctrl_a.speed = speed_a_s1;
		ctrl_b.tick  = 1'b0;
		ctrl_b.apply = 1'b0;
		ctrl_b.speed = speed_b_s1;
		unique case (hbpd_pkg::kind_t'(kind_s1))
			hbpd_pkg::KIND_TICK: begin
				ctrl_a.tick = 1'b1;
				ctrl_b.tick = 1'b1;
			end
			hbpd_pkg::KIND_UPDATE: begin
				// fault pin is sampled only while the latch is clear
				if (!latch_q) begin
					event_nxt = !fault_pin_s1;
					latch_nxt = !fault_pin_s1 && !auto_clear_q;
				end
				ctrl_a.apply = 1'b1;
				ctrl_b.apply = 1'b1;
				if (latch_nxt) begin
					sleep_nxt    = 1'b0;
					ctrl_a.speed = '0;
					ctrl_b.speed = '0;
				end else begin
					sleep_nxt = (speed_a_s1 != '0) || (speed_b_s1 != '0);
				end
			end
			hbpd_pkg::KIND_CLEAR: begin
				latch_nxt = 1'b0;
			end
			default: begin
			end
		endcase
	end

	hbpd_chan #(
		.SPEED_RESOLUTION(SPEED_RESOLUTION)
	) u_chan_a (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (proc),
		.ctrl  (ctrl_a),
		.pin1  (pa1),
		.pin2  (pa2)
	);

	hbpd_chan #(
		.SPEED_RESOLUTION(SPEED_RESOLUTION)
	) u_chan_b (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (proc),
		.ctrl  (ctrl_b),
		.pin1  (pb1),
		.pin2  (pb2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			auto_clear_q <= 1'b1;
			latch_q      <= 1'b0;
			sleep_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				auto_clear_q <= cfg_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (proc) begin
				out_valid_q <= 1'b1;
				latch_q     <= latch_nxt;
				sleep_q     <= sleep_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1      <= kind;
			speed_a_s1   <= speed_a;
			speed_b_s1   <= speed_b;
			fault_pin_s1 <= fault_pin;
		end
		if (proc) begin
			pin_a1_q <= pa1;
			pin_a2_q <= pa2;
			pin_b1_q <= pb1;
			pin_b2_q <= pb2;
			event_q  <= event_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign pin_a1       = pin_a1_q;
	assign pin_a2       = pin_a2_q;
	assign pin_b1       = pin_b1_q;
	assign pin_b2       = pin_b2_q;
	assign sleep_n      = sleep_q;
	assign fault_active = latch_q;
	assign fault_event  = event_q;

endmodule

### sv/hbpd_chan.sv
// One PWM channel: period counter, last applied speed and compare pair.
// Depends on hbpd_pkg. Pin outputs reflect the state after this word.
module hbpd_chan #(
	parameter int SPEED_RESOLUTION = hbpd_pkg::SPEED_RES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  hbpd_pkg::chan_ctrl_t ctrl,
	output logic                 pin1,
	output logic                 pin2
);

	localparam int CW = hbpd_pkg::CNT_W;
	localparam int SW = hbpd_pkg::SPEED_W;
	localparam logic [CW-1:0] RES = CW'(SPEED_RESOLUTION);
	localparam logic [SW:0]   RES9 = (SW+1)'(SPEED_RESOLUTION);

	logic [CW-1:0] count_q, cmp0_q, cmp1_q;
	logic [SW-1:0] last_q;
	logic [CW-1:0] count_nxt, cmp0_nxt, cmp1_nxt;
	logic [SW-1:0] last_nxt;
	logic [CW:0]   inc;
	logic [SW:0]   spd9, diff9, sum9;
	logic          changed;

	always_comb begin
		inc     = {1'b0, count_q} + (CW+1)'(1);
		spd9    = {ctrl.speed[SW-1], ctrl.speed};
		diff9   = RES9 - spd9;
		sum9    = RES9 + spd9;
		changed = ctrl.apply && (ctrl.speed != last_q);

		count_nxt = count_q;
		cmp0_nxt  = cmp0_q;
		cmp1_nxt  = cmp1_q;
		last_nxt  = last_q;
		if (ctrl.tick) begin
			count_nxt = (inc >= (CW+1)'(SPEED_RESOLUTION)) ? '0 : inc[CW-1:0];
		end
		if (changed) begin
			last_nxt  = ctrl.speed;
			count_nxt = '0;
			// forward drive lowers compare 0, reverse lowers compare 1; clamp at 0
			if (ctrl.speed[SW-1]) begin
				cmp0_nxt = RES;
				cmp1_nxt = sum9[SW] ? '0 : sum9[CW-1:0];
			end else begin
				cmp0_nxt = diff9[SW] ? '0 : diff9[CW-1:0];
				cmp1_nxt = RES;
			end
		end
		pin1 = count_nxt < cmp0_nxt;
		pin2 = count_nxt < cmp1_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			last_q  <= '0;
			cmp0_q  <= RES;
			cmp1_q  <= RES;
		end else if (en) begin
			count_q <= count_nxt;
			last_q  <= last_nxt;
			cmp0_q  <= cmp0_nxt;
			cmp1_q  <= cmp1_nxt;
		end
	end

endmodule

### sv/hbpd_checker.sv
// Port-level checker for dual_hbridge_pwm_driver, bound to the top level.
// Depends on dual_hbridge_pwm_driver_macros.svh.
`include "dual_hbridge_pwm_driver_macros.svh"

module hbpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       pin_a1,
	input logic       pin_a2,
	input logic       pin_b1,
	input logic       pin_b2,
	input logic       sleep_n,
	input logic       fault_active,
	input logic       fault_event
);

	logic [6:0] res_word;
	logic       held, valid_fault;
	logic       a_one_high, b_one_high, all_high;

	assign res_word    = {pin_a1, pin_a2, pin_b1, pin_b2, sleep_n, fault_active, fault_event};
	assign held        = out_valid && out_stall;
	assign valid_fault = out_valid && fault_active;
	assign a_one_high  = pin_a1 || pin_a2;
	assign b_one_high  = pin_b1 || pin_b2;
	assign all_high    = pin_a1 && pin_a2 && pin_b1 && pin_b2;

	// a held result word must not move
	`HBPD_ASSERT_IMPL(a_out_hold, held, ##1 (out_valid && $stable(res_word)), "held word moved")

	// slow decay: a channel never drives both bridge inputs low
	`HBPD_ASSERT_IMPL(a_no_coast, out_valid, a_one_high && b_one_high, "channel pins both low")

	// a latched fault keeps the driver asleep
	`HBPD_ASSERT_IMPL(a_fault_sleep, valid_fault, !sleep_n, "awake with fault latched")

	// a latched fault forces zero speed, i.e. brake on all pins
	`HBPD_ASSERT_IMPL(a_fault_brake, valid_fault, all_high, "drive with fault latched")

endmodule

bind dual_hbridge_pwm_driver hbpd_checker u_hbpd_checker (.*);

### bench/dual_hbridge_pwm_driver_checker.sv
// Checker for the dual H-bridge PWM driver: follows the config, input and result channels.
// It predicts each result word and compares it with what the block returns.
// Depends on hbpd_pkg.
module dual_hbridge_pwm_driver_checker
	import hbpd_pkg::*;
#(
	parameter int SPEED_RESOLUTION = SPEED_RES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [SPEED_W-1:0] speed_a,
	input  logic [SPEED_W-1:0] speed_b,
	input  logic               fault_pin,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               pin_a1,
	input  logic               pin_a2,
	input  logic               pin_b1,
	input  logic               pin_b2,
	input  logic               sleep_n,
	input  logic               fault_active,
	input  logic               fault_event,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic a1;
		logic a2;
		logic b1;
		logic b2;
		logic awake;
		logic latched;
		logic detect;
	} pin_word_t;

	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic [SPEED_W-1:0] applied;
		logic [CNT_W-1:0]   cmp_fwd;
		logic [CNT_W-1:0]   cmp_rev;
	} bridge_t;

	localparam bridge_t BRIDGE_RESET = '{
		count:   '0,
		applied: '0,
		cmp_fwd: CNT_W'(SPEED_RESOLUTION),
		cmp_rev: CNT_W'(SPEED_RESOLUTION)
	};

	bridge_t   bridge_a, bridge_b;
	logic      latch_q;
	logic      awake_q;
	logic      clear_on_detect;
	pin_word_t pin_words_due[$];
	pin_word_t exp_w, got_w;

	// new speed: clamp, map to the compare pair, restart the counter
	function automatic bridge_t retarget(bridge_t ch, logic [SPEED_W-1:0] raw);
		int s, fwd, rev;
		s = $signed(raw);
		if (raw == ch.applied)
			return ch;
		fwd = (s < 0) ? 0 : ((s > SPEED_RESOLUTION) ? SPEED_RESOLUTION : s);
		rev = (s > 0) ? 0 : ((s < -SPEED_RESOLUTION) ? -SPEED_RESOLUTION : s);
		ch.applied = raw;
		ch.cmp_fwd = CNT_W'(SPEED_RESOLUTION - fwd);
		ch.cmp_rev = CNT_W'(SPEED_RESOLUTION + rev);
		ch.count   = '0;
		return ch;
	endfunction

	function automatic bridge_t advance(bridge_t ch);
		if (int'(ch.count) + 1 >= SPEED_RESOLUTION)
			ch.count = '0;
		else
			ch.count = ch.count + 1'b1;
		return ch;
	endfunction

	function automatic pin_word_t drive_word(logic [1:0] k, logic [SPEED_W-1:0] sa,
			logic [SPEED_W-1:0] sb, logic fp);
		pin_word_t w;
		logic      detect;
		detect = 1'b0;
		case (kind_t'(k))
			KIND_TICK: begin
				bridge_a = advance(bridge_a);
				bridge_b = advance(bridge_b);
			end
			KIND_UPDATE: begin
				// an already latched fault masks the pin
				if (!latch_q && !fp) begin
					detect  = 1'b1;
					latch_q = !clear_on_detect;
				end
				if (latch_q) begin
					awake_q  = 1'b0;
					bridge_a = retarget(bridge_a, '0);
					bridge_b = retarget(bridge_b, '0);
				end else begin
					awake_q  = (sa != '0) || (sb != '0);
					bridge_a = retarget(bridge_a, sa);
					bridge_b = retarget(bridge_b, sb);
				end
			end
			KIND_CLEAR: latch_q = 1'b0;
			default: ;
		endcase
		w.a1      = bridge_a.count < bridge_a.cmp_fwd;
		w.a2      = bridge_a.count < bridge_a.cmp_rev;
		w.b1      = bridge_b.count < bridge_b.cmp_fwd;
		w.b2      = bridge_b.count < bridge_b.cmp_rev;
		w.awake   = awake_q;
		w.latched = latch_q;
		w.detect  = detect;
		return w;
	endfunction

	task automatic check_field(string name, logic e, logic g);
		if (g !== e) begin
			$display("%0t ns: %s expected %0b got %0b", $time, name, e, g);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bridge_a        = BRIDGE_RESET;
			bridge_b        = BRIDGE_RESET;
			latch_q         = 1'b0;
			awake_q         = 1'b0;
			clear_on_detect = 1'b1;
			pin_words_due.delete();
			fail_count      = 0;
			pending         = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				clear_on_detect = cfg_data;
			if (out_valid && !out_stall) begin
				got_w = {pin_a1, pin_a2, pin_b1, pin_b2, sleep_n, fault_active, fault_event};
				if (pin_words_due.size() == 0) begin
					$display("%0t ns: result word with none expected, got %b", $time, got_w);
					fail_count++;
				end else begin
					exp_w = pin_words_due.pop_front();
					check_field("pin_a1", exp_w.a1, got_w.a1);
					check_field("pin_a2", exp_w.a2, got_w.a2);
					check_field("pin_b1", exp_w.b1, got_w.b1);
					check_field("pin_b2", exp_w.b2, got_w.b2);
					check_field("sleep_n", exp_w.awake, got_w.awake);
					check_field("fault_active", exp_w.latched, got_w.latched);
					check_field("fault_event", exp_w.detect, got_w.detect);
				end
			end
			if (in_valid && !in_stall)
				pin_words_due.push_back(drive_word(kind, speed_a, speed_b, fault_pin));
			pending = pin_words_due.size();
		end
	end

endmodule

### bench/dual_hbridge_pwm_driver_test.sv
// Top of the dual H-bridge PWM driver bench: clock, reset, stimulus and verdict.
// Depends on hbpd_pkg, dual_hbridge_pwm_driver and dual_hbridge_pwm_driver_checker.
module dual_hbridge_pwm_driver_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hbpd_pkg::*;

	localparam logic [1:0] KIND_UNUSED  = 2'd3;
	localparam int         IDLE_LIMIT   = 2000;
	localparam int         HOLD_CYCLES  = 80;
	localparam int         DRAIN_CYCLES = 8;
	localparam int         PHASES       = 6;
	localparam int         PHASE_WORDS  = 90;
	localparam int         TICK_RUN     = 110;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid, cfg_ready, cfg_data;
	logic               in_valid, in_stall;
	logic [1:0]         kind;
	logic [SPEED_W-1:0] speed_a, speed_b;
	logic               fault_pin;
	logic               out_valid, out_stall;
	logic               pin_a1, pin_a2, pin_b1, pin_b2;
	logic               sleep_n, fault_active, fault_event;
	int                 fail_count, pending;

	logic               steady;
	logic               hold_req;
	logic [SPEED_W-1:0] last_sa, last_sb;

	dual_hbridge_pwm_driver u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .speed_a(speed_a), .speed_b(speed_b), .fault_pin(fault_pin),
		.out_valid(out_valid), .out_stall(out_stall),
		.pin_a1(pin_a1), .pin_a2(pin_a2), .pin_b1(pin_b1), .pin_b2(pin_b2),
		.sleep_n(sleep_n), .fault_active(fault_active), .fault_event(fault_event)
	);

	dual_hbridge_pwm_driver_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .speed_a(speed_a), .speed_b(speed_b), .fault_pin(fault_pin),
		.out_valid(out_valid), .out_stall(out_stall),
		.pin_a1(pin_a1), .pin_a2(pin_a2), .pin_b1(pin_b1), .pin_b2(pin_b2),
		.sleep_n(sleep_n), .fault_active(fault_active), .fault_event(fault_event),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// entered and left on a falling edge
	task automatic push_word(logic [1:0] k, logic [SPEED_W-1:0] sa, logic [SPEED_W-1:0] sb,
			logic fp);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		kind      = k;
		speed_a   = sa;
		speed_b   = sb;
		fault_pin = fp;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic set_auto_clear(logic v);
		in_valid = 1'b0;
		wait (pending == 0);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [SPEED_W-1:0] pick_speed(logic [SPEED_W-1:0] prev);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return prev;
			2: return $urandom_range(0, 1) ? 8'h7F : 8'h80;
			3: return SPEED_W'(int'($urandom_range(0, 200)) - 100);
			4: return SPEED_W'(int'($urandom_range(0, 10)) - 5);
			default: return SPEED_W'($urandom);
		endcase
	endfunction

	task automatic random_word();
		int                 r;
		logic [1:0]         k;
		logic [SPEED_W-1:0] sa, sb;
		r  = $urandom_range(0, 99);
		k  = (r < 45) ? KIND_TICK : (r < 85) ? KIND_UPDATE : (r < 93) ? KIND_CLEAR : KIND_UNUSED;
		sa = pick_speed(last_sa);
		sb = pick_speed(last_sb);
		push_word(k, sa, sb, $urandom_range(0, 9) != 0);
		if (k == KIND_UPDATE) begin
			last_sa = sa;
			last_sb = sb;
		end
	endtask

	// long enough for both counters to wrap
	task automatic tick_run();
		repeat (TICK_RUN)
			push_word(KIND_TICK, SPEED_W'($urandom), SPEED_W'($urandom), 1'($urandom));
	endtask

	// result side: random hold-off per word, plus one long hold on request
	initial begin
		int wait_n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			wait_n = steady ? 0 : $urandom_range(0, 3);
			if (wait_n > 0) begin
				out_stall = 1'b1;
				repeat (wait_n) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = 1'b0;
		in_valid  = 1'b0;
		kind      = KIND_TICK;
		speed_a   = '0;
		speed_b   = '0;
		fault_pin = 1'b1;
		steady    = 1'b0;
		hold_req  = 1'b0;
		last_sa   = '0;
		last_sb   = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// auto_clear still at its reset value
		push_word(KIND_UPDATE, 8'h7F, 8'h80, 1'b1);
		push_word(KIND_TICK, 8'h00, 8'h00, 1'b0);
		push_word(KIND_TICK, 8'hFF, 8'hFF, 1'b1);
		push_word(KIND_UPDATE, 8'h7F, 8'h80, 1'b1);
		push_word(KIND_UPDATE, 8'h00, 8'h00, 1'b1);
		push_word(KIND_UPDATE, 8'd100, -8'sd100, 1'b0);
		push_word(KIND_UNUSED, 8'h55, 8'hAA, 1'b0);
		push_word(KIND_CLEAR, 8'h00, 8'h00, 1'b1);
		push_word(KIND_UPDATE, 8'd1, 8'hFF, 1'b1);
		push_word(KIND_TICK, 8'h00, 8'h00, 1'b1);

		// latched faults force sleep and zero speed
		set_auto_clear(1'b0);
		push_word(KIND_UPDATE, -8'sd50, 8'd50, 1'b0);
		push_word(KIND_UPDATE, 8'd20, 8'd20, 1'b1);
		push_word(KIND_UPDATE, 8'd20, 8'd20, 1'b0);
		push_word(KIND_TICK, 8'h00, 8'h00, 1'b1);
		push_word(KIND_UNUSED, 8'h00, 8'h00, 1'b1);
		push_word(KIND_CLEAR, 8'h00, 8'h00, 1'b1);
		push_word(KIND_UPDATE, 8'd20, -8'sd20, 1'b1);
		push_word(KIND_UPDATE, 8'd101, -8'sd101, 1'b1);
		push_word(KIND_UPDATE, 8'h80, 8'h7F, 1'b1);
		push_word(KIND_TICK, 8'h00, 8'h00, 1'b1);
		last_sa = 8'h80;
		last_sb = 8'h7F;

		for (int phase = 0; phase < PHASES; phase++) begin
			set_auto_clear(phase[0]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 30 == 0)
					steady = ($urandom_range(0, 2) == 0);
				if (phase == 2 && n == 30)
					hold_req = 1'b1;
				if (phase == 3 && n == 45) begin
					in_valid = 1'b0;
					wait (pending == 0);
					@(negedge clk);
				end
				if ((phase == 1 || phase == 4) && n == 20)
					tick_run();
				random_word();
			end
		end

		in_valid = 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
